FILE: hw/rtl/lss_pkg.sv
// Shared types and constants for the lexicon sentiment scorer.
package lss_pkg;

  // Lexicon size and longest lexicon word.
  localparam int LEX_COUNT  = 8;
  localparam int LEX_MAXLEN = 9;

  // Configuration index width; indexes at or above LEX_COUNT are ignored.
  localparam int CFG_INDEX_BITS = 8;

  // Sentiment class codes.
  localparam logic [1:0] CLASS_POSITIVE = 2'd0;
  localparam logic [1:0] CLASS_NEGATIVE = 2'd1;
  localparam logic [1:0] CLASS_NEUTRAL  = 2'd2;

  // Lexicon spelling, one row per word, padded with zero bytes.
  localparam logic [7:0] LEX_TEXT [LEX_COUNT][LEX_MAXLEN] = '{
    '{"g", "o", "o", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "a", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "x", "c", "e", "l", "l", "e", "n", "t"},
    '{"s", "u", "c", "c", "e", "s", "s", 8'h00, 8'h00},
    '{"b", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "e", "r", "r", "i", "b", "l", "e", 8'h00},
    '{"f", "a", "i", "l", "u", "r", "e", 8'h00, 8'h00},
    '{"c", "r", "i", "s", "i", "s", 8'h00, 8'h00, 8'h00}
  };

  // Length of each lexicon word.
  localparam logic [3:0] LEX_LEN [LEX_COUNT] = '{
    4'd4, 4'd5, 4'd9, 4'd7, 4'd3, 4'd8, 4'd7, 4'd6
  };

  // Weight values after reset.
  localparam logic [7:0] WEIGHT_RESET [LEX_COUNT] = '{
    8'h01, 8'h02, 8'h03, 8'h02, 8'hFF, 8'hFD, 8'hFE, 8'hFE
  };

  // All eight weights, element i belongs to lexicon word i.
  typedef logic [LEX_COUNT-1:0][7:0] weight_vec_t;

  // One input item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } byte_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         sentiment_class;
    logic signed [15:0] total_score;
  } result_item_t;

endpackage

FILE: hw/rtl/lss_weight_regs.sv
// Configuration register file holding the eight signed word weights.
module lss_weight_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                         cfg_data,
  output lss_pkg::weight_vec_t               weight
);
  import lss_pkg::*;

  // A write beyond the lexicon is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEX_COUNT; i++) begin
        weight[i] <= WEIGHT_RESET[i];
      end
    end else if (cfg_write && (cfg_index < CFG_INDEX_BITS'(LEX_COUNT))) begin
      weight[cfg_index[$clog2(LEX_COUNT)-1:0]] <= cfg_data;
    end
  end

endmodule

FILE: hw/rtl/lss_word_tracker.sv
// Word gathering and lexicon prefix matching for one byte per cycle while step is high.
module lss_word_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  lss_pkg::byte_item_t          item,
  output logic [lss_pkg::LEX_COUNT-1:0] hit
);
  import lss_pkg::*;

  logic [3:0]           word_length;
  logic [3:0]           word_length_next;
  logic [LEX_COUNT-1:0] words_still_matching;
  logic [LEX_COUNT-1:0] words_still_matching_next;

  logic                 is_upper;
  logic                 is_lower;
  logic                 is_letter;
  logic [7:0]           letter;
  logic [3:0]           pos;
  logic [LEX_COUNT-1:0] keep;
  logic [3:0]           len_add;
  logic [LEX_COUNT-1:0] mask_add;
  logic [3:0]           fin_len;
  logic [LEX_COUNT-1:0] fin_mask;
  logic                 finish;

  // Classify the byte and fold capitals to lower case.
  assign is_upper  = (item.text_byte >= "A") && (item.text_byte <= "Z");
  assign is_lower  = (item.text_byte >= "a") && (item.text_byte <= "z");
  assign is_letter = is_upper || is_lower;
  assign letter    = is_upper ? (item.text_byte | 8'h20) : item.text_byte;

  // Compare the letter against each lexicon word at the current position.
  assign pos = (word_length < 4'(LEX_MAXLEN)) ? word_length : 4'd0;

  always_comb begin
    for (int i = 0; i < LEX_COUNT; i++) begin
      keep[i] = (word_length < LEX_LEN[i]) && (LEX_TEXT[i][pos] == letter);
    end
  end

  assign len_add  = (word_length == 4'd15) ? word_length : word_length + 4'd1;
  assign mask_add = words_still_matching & keep;

  // A letter on the final byte joins the word before it is scored.
  assign fin_len  = is_letter ? len_add : word_length;
  assign fin_mask = is_letter ? mask_add : words_still_matching;
  assign finish   = !is_letter || item.end_of_text;

  always_comb begin
    for (int i = 0; i < LEX_COUNT; i++) begin
      hit[i] = step && finish && fin_mask[i] && (fin_len == LEX_LEN[i]);
    end
  end

  // A finished word clears the tracker; otherwise the word grows.
  always_comb begin
    word_length_next          = word_length;
    words_still_matching_next = words_still_matching;
    if (step) begin
      if (finish) begin
        word_length_next          = 4'd0;
        words_still_matching_next = '1;
      end else begin
        word_length_next          = len_add;
        words_still_matching_next = mask_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length          <= 4'd0;
      words_still_matching <= '1;
    end else begin
      word_length          <= word_length_next;
      words_still_matching <= words_still_matching_next;
    end
  end

endmodule

FILE: hw/rtl/lss_score_acc.sv
// Saturating score accumulator and sentiment classification.
module lss_score_acc #(
  parameter int SCORE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          last,
  input  logic [lss_pkg::LEX_COUNT-1:0] hit,
  input  lss_pkg::weight_vec_t          weight,
  output lss_pkg::result_item_t         result
);
  import lss_pkg::*;

  localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  logic signed [SCORE_BITS-1:0] running_score;
  logic signed [SCORE_BITS-1:0] running_score_next;
  logic [7:0]                   sel_weight;
  logic signed [SCORE_BITS:0]   sum;
  logic signed [SCORE_BITS-1:0] sat_sum;
  logic signed [SCORE_BITS-1:0] score_fin;
  logic signed [31:0]           score_wide;

  // At most one lexicon word matches, so an OR selects its weight.
  always_comb begin
    sel_weight = 8'h00;
    for (int i = 0; i < LEX_COUNT; i++) begin
      sel_weight = sel_weight | (hit[i] ? weight[i] : 8'h00);
    end
  end

  // Add with one guard bit and clamp on overflow.
  assign sum = (SCORE_BITS+1)'(running_score) + (SCORE_BITS+1)'($signed(sel_weight));

  always_comb begin
    if (sum[SCORE_BITS] != sum[SCORE_BITS-1]) begin
      sat_sum = sum[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
    end else begin
      sat_sum = sum[SCORE_BITS-1:0];
    end
  end

  assign score_fin = (|hit) ? sat_sum : running_score;

  // Result fields: class from the full score, score taken to 16 bits.
  assign score_wide = 32'(score_fin);

  always_comb begin
    result.total_score = score_wide[15:0];
    if (score_fin > 0) begin
      result.sentiment_class = CLASS_POSITIVE;
    end else if (score_fin < 0) begin
      result.sentiment_class = CLASS_NEGATIVE;
    end else begin
      result.sentiment_class = CLASS_NEUTRAL;
    end
  end

  // The score returns to zero after the final byte of a text.
  always_comb begin
    running_score_next = running_score;
    if (step) begin
      running_score_next = last ? '0 : score_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_score <= '0;
    end else begin
      running_score <= running_score_next;
    end
  end

endmodule

FILE: hw/rtl/lexicon_sentiment_scorer_unit.sv
// Top level of the lexicon sentiment scorer: input register, scoring, result register.
//
// Text enters on the byte channel, one byte per item, with end_of_text set on the
// final byte. An item is taken at a clock edge where byte_valid is high and
// byte_stall is low. Letters are folded to lower case and gathered into words;
// every other byte ends a word, and a word that equals a lexicon entry adds its
// weight to a saturating score.
// Only the final byte of a text yields an item on the result channel: the class
// and the score. It passes from the input register into the result register
// once any earlier result has been taken, and waits in the result register
// until the receiver lowers result_stall.
// Throughput is one byte per cycle while byte_stall is low; a byte is scored
// combinationally between the input register and the result register.
// While the result register holds an item the receiver stalls, ordinary bytes
// keep flowing; only the next final byte waits, and byte_stall rises behind it.
// Weights are written on the cfg channel (index 0 to 7, others ignored), which
// is always ready. Reset (rst, synchronous) restores default weights and clears
// the word and the score.
module lexicon_sentiment_scorer_unit #(
  parameter int SCORE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  lss_pkg::byte_item_t                byte_item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output lss_pkg::result_item_t              result_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                         cfg_data
);
  import lss_pkg::*;

  logic                 s1_valid;
  byte_item_t           s1_item;
  logic                 s1_go;
  logic                 result_load;
  weight_vec_t          weight;
  logic [LEX_COUNT-1:0] hit;
  result_item_t         result;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  lss_weight_regs u_weight_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .weight    (weight)
  );

  // A registered byte moves on unless it is final and the result register is held.
  assign s1_go       = s1_valid && !(s1_item.end_of_text && result_valid && result_stall);
  assign byte_stall  = s1_valid && !s1_go;
  assign result_load = s1_go && s1_item.end_of_text;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      s1_item <= byte_item;
    end
  end

  // Word tracking and scoring of the registered byte.
  lss_word_tracker u_word_tracker (
    .clk  (clk),
    .rst  (rst),
    .step (s1_go),
    .item (s1_item),
    .hit  (hit)
  );

  lss_score_acc #(
    .SCORE_BITS (SCORE_BITS)
  ) u_score_acc (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_go),
    .last   (s1_item.end_of_text),
    .hit    (hit),
    .weight (weight),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result_item <= result;
    end
  end

  // The input side only stalls when a byte is already held.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> s1_valid)
    else $error("byte_stall raised with an empty input register");

  // A new result only ever comes from a final byte.
  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid && s1_item.end_of_text))
    else $error("result appeared without a final byte");

  // A final byte must wait while an earlier result is still held.
  a_final_waits: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall && s1_valid && s1_item.end_of_text) |-> byte_stall)
    else $error("final byte not held behind a pending result");

  // A neutral class always carries a zero score.
  a_neutral_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_item.sentiment_class == CLASS_NEUTRAL))
      |-> (result_item.total_score == 16'sd0))
    else $error("neutral class with non-zero score");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the lexicon sentiment scorer unit.
module tb_top;
  import lss_pkg::*;

  // Register indexes of the word weights.
  localparam int REG_WEIGHT_GOOD      = 0;
  localparam int REG_WEIGHT_GREAT     = 1;
  localparam int REG_WEIGHT_EXCELLENT = 2;
  localparam int REG_WEIGHT_SUCCESS   = 3;
  localparam int REG_WEIGHT_BAD       = 4;
  localparam int REG_WEIGHT_TERRIBLE  = 5;
  localparam int REG_WEIGHT_FAILURE   = 6;
  localparam int REG_WEIGHT_CRISIS    = 7;

  localparam int SCORE_MAX    = 32767;
  localparam int SCORE_MIN    = -32768;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {PLAN_RANDOM, PLAN_EXTREME, PLAN_MIXED} weight_plan_t;

  // One text byte, with the verdict typed in where the text ends and it is obvious.
  typedef struct {
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       pinned;
    logic [1:0] verdict;
    int         score;
  } text_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      byte_valid = 1'b0;
  logic                      byte_stall;
  byte_item_t                byte_item = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  result_item_t              result_item;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [7:0]                cfg_data = '0;

  lexicon_sentiment_scorer_unit DUT (.*);

  always #2 clk = ~clk;

  // Directed texts, all scored with the weights left by reset.
  text_row_t directed_rows [23] = '{
    '{".",   1'b1, 1'b1, CLASS_NEUTRAL,  0},
    '{"g",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"O",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"o",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"D",   1'b1, 1'b1, CLASS_POSITIVE, 1},
    '{"B",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"A",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"D",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{8'hFF, 1'b1, 1'b1, CLASS_NEGATIVE, -1},
    '{8'h00, 1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"C",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"r",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"i",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"s",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"i",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"s",   1'b1, 1'b1, CLASS_NEGATIVE, -2},
    // Bytes just outside the letter ranges, and two separators in a row.
    '{"Z",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{8'h40, 1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{8'h5B, 1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"a",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{8'h60, 1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{"z",   1'b0, 1'b0, CLASS_NEUTRAL,  0},
    '{8'h7B, 1'b1, 1'b1, CLASS_NEUTRAL,  0}
  };

  // Scorer state as the testbench sees it.
  string lexicon [LEX_COUNT] = '{"good", "great", "excellent", "success",
                                 "bad", "terrible", "failure", "crisis"};
  logic signed [7:0] lexicon_weight [LEX_COUNT] = '{8'sd1, 8'sd2, 8'sd3, 8'sd2,
                                                    -8'sd1, -8'sd3, -8'sd2, -8'sd2};
  logic [3:0]        word_len = '0;
  logic [7:0]        live_words = '1;
  int                running_total = 0;

  result_item_t      expected_verdicts [$];
  text_row_t         pinned_q [$];
  logic [7:0]        text_buf [$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int stall_run = 0;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [7:0] random_separator();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_letter(b));
    return b;
  endfunction

  // A lower-case letter narrows the set of lexicon words still in the running.
  function void take_letter(input logic [7:0] c);
    logic [7:0] keep;
    keep = '0;
    for (int i = 0; i < LEX_COUNT; i++) begin
      if (word_len < lexicon[i].len() && lexicon[i][word_len] == c) keep[i] = 1'b1;
    end
    live_words &= keep;
    if (word_len != 4'd15) word_len++;
  endfunction

  // A finished word adds the weight of the lexicon word it equals, saturating.
  function void close_word();
    int sum;
    for (int i = 0; i < LEX_COUNT; i++) begin
      if (live_words[i] && word_len == lexicon[i].len()) begin
        sum = running_total + lexicon_weight[i];
        if (sum > SCORE_MAX) sum = SCORE_MAX;
        if (sum < SCORE_MIN) sum = SCORE_MIN;
        running_total = sum;
      end
    end
    word_len = '0;
    live_words = '1;
  endfunction

  // Advances the scorer by one byte and records the verdict a final byte yields.
  function void predict_text_byte(input byte_item_t it);
    text_row_t    pin;
    result_item_t verdict;
    if (is_letter(it.text_byte)) take_letter(it.text_byte | 8'h20);
    else close_word();
    if (it.end_of_text) begin
      close_word();
      if (running_total > 0) verdict.sentiment_class = CLASS_POSITIVE;
      else if (running_total < 0) verdict.sentiment_class = CLASS_NEGATIVE;
      else verdict.sentiment_class = CLASS_NEUTRAL;
      verdict.total_score = running_total[15:0];
      running_total = 0;
      pin = pinned_q.pop_front();
      if (pin.pinned) begin
        verdict.sentiment_class = pin.verdict;
        verdict.total_score = pin.score[15:0];
      end
      expected_verdicts = {expected_verdicts, verdict};
    end
  endfunction

  function void flag_mismatch(input string what, input string want, input string got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch in %s: expected %s, got %s", what, want, got);
  endfunction

  // Checks verdicts, follows the weight writes, predicts each byte and minds the watchdog.
  always @(posedge clk) begin
    result_item_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result with nothing pending", "none",
                        $sformatf("class %0d score %0d", result_item.sentiment_class,
                                  result_item.total_score));
        end else begin
          want = expected_verdicts.pop_front();
          if (result_item.sentiment_class !== want.sentiment_class)
            flag_mismatch("sentiment_class", $sformatf("%0d", want.sentiment_class),
                          $sformatf("%0d", result_item.sentiment_class));
          if (result_item.total_score !== want.total_score)
            flag_mismatch("total_score", $sformatf("%0d", want.total_score),
                          $sformatf("%0d", result_item.total_score));
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < LEX_COUNT) lexicon_weight[cfg_index] = cfg_data;
      if (byte_valid && !byte_stall) predict_text_byte(byte_item);
      if ((result_valid && !result_stall) || (byte_valid && !byte_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // The receiver alternates free-running stretches, random stalls and long stalls.
  always @(posedge clk) begin
    int mode;
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        result_stall <= 1'b0;
        stall_run = $urandom_range(10, 60);
      end else if (mode < 7) begin
        result_stall <= 1'($urandom_range(0, 1));
        stall_run = $urandom_range(0, 3);
      end else begin
        result_stall <= 1'b1;
        stall_run = $urandom_range(1, 20);
      end
    end
  end

  // Offers one byte, opening a gap first when the current burst is used up.
  task send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_item <= '{text_byte: b, end_of_text: eot};
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
  endtask

  task send_text();
    text_row_t tag;
    tag = '{default: '0};
    foreach (text_buf[k]) begin
      if (k == text_buf.size() - 1) pinned_q = {pinned_q, tag};
      send_byte(text_buf[k], k == text_buf.size() - 1);
    end
    text_buf.delete();
  endtask

  // Holds the sender until every verdict is in and the pipeline has emptied.
  task drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Rewrites every weight once the scorer is idle, plus one write to an unused index.
  task load_weights(input weight_plan_t plan);
    logic [7:0] value;
    drain();
    for (int r = REG_WEIGHT_GOOD; r <= REG_WEIGHT_CRISIS; r++) begin
      case (plan)
        PLAN_EXTREME: value = r[0] ? 8'h80 : 8'h7F;
        PLAN_MIXED: begin
          case ($urandom_range(0, 5))
            0: value = 8'h80;
            1: value = 8'h7F;
            2: value = 8'h00;
            3: value = 8'hFF;
            4: value = 8'h01;
            default: value = 8'($urandom_range(0, 255));
          endcase
        end
        default: value = 8'($urandom_range(0, 255));
      endcase
      write_reg(8'(r), value);
    end
    if (plan == PLAN_EXTREME) write_reg(8'hFF, 8'($urandom_range(0, 255)));
    else write_reg(8'($urandom_range(LEX_COUNT, 255)), 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  // Random texts: mostly lexicon words and near misses, with junk words and separators.
  task run_random_phase(input int budget);
    int         start;
    int         tokens;
    int         pick;
    int         len;
    int         pos;
    string      w;
    logic [7:0] c;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
        pick = $urandom_range(0, 9);
        w = lexicon[$urandom_range(0, LEX_COUNT - 1)];
        if (pick == 8) len = $urandom_range(1, 20);
        else if (pick == 9) len = 0;
        else len = w.len() - (pick == 5) + (pick == 6);
        pos = $urandom_range(0, w.len() - 1);
        for (int p = 0; p < len; p++) begin
          if (pick == 8 || p >= w.len() || (pick == 7 && p == pos))
            c = 8'($urandom_range(0, 25) + 8'h61);
          else
            c = w[p];
          text_buf = {text_buf, c ^ (8'($urandom_range(0, 1)) << 5)};
        end
        // The last word may run straight into the end of the text.
        if (t < tokens - 1 || $urandom_range(0, 1))
          repeat ($urandom_range(1, 3)) text_buf = {text_buf, random_separator()};
      end
      if (text_buf.size() == 0) text_buf = {text_buf, random_separator()};
      send_text();
      if ($urandom_range(0, 15) == 0) drain();
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].end_of_text) pinned_q = {pinned_q, directed_rows[k]};
      send_byte(directed_rows[k].text_byte, directed_rows[k].end_of_text);
    end
    load_weights(PLAN_RANDOM);
    run_random_phase(200);
    load_weights(PLAN_EXTREME);
    run_random_phase(200);
    load_weights(PLAN_MIXED);
    run_random_phase(300);
    drain();
    if (expected_verdicts.size() != 0)
      flag_mismatch("end of run", "no pending verdicts",
                    $sformatf("%0d pending", expected_verdicts.size()));
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
